### src/ygcd_pkg.sv
// ----------------------------------------------------------------------------
// ygcd_pkg
// Shared types and constants of the grid cell decoder: register indexes,
// configuration record, sequencer operations and the control/status records.
// ----------------------------------------------------------------------------
package ygcd_pkg;

   localparam logic [6:0] MAX_CLASSES = 7'd80;

   // configuration register indexes
   localparam logic [2:0] REG_SCALE_LEVEL  = 3'd0;
   localparam logic [2:0] REG_ZERO_POINT   = 3'd1;
   localparam logic [2:0] REG_QUANT_SCALE  = 3'd2;
   localparam logic [2:0] REG_THRESHOLD_Q  = 3'd3;
   localparam logic [2:0] REG_CLASS_COUNT  = 3'd4;
   localparam logic [2:0] REG_FILTER_ON    = 3'd5;
   localparam logic [2:0] REG_CLASS_MASK   = 3'd6;

   typedef struct packed {
      logic [1:0]         scale_level;
      logic signed [7:0]  zero_point;
      logic [23:0]        quant_scale;
      logic signed [7:0]  threshold_q;
      logic [6:0]         class_count;
      logic               class_filter_on;
      logic [63:0]        class_mask;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      scale_level:     2'd0,
      zero_point:      8'sd0,
      quant_scale:     24'd4096,
      threshold_q:     8'sd0,
      class_count:     7'd80,
      class_filter_on: 1'b0,
      class_mask:      64'd0
   };

   // anchor width/height pairs per scale level
   localparam logic [8:0] ANCHOR_TAB [0:2][0:5] = '{
      '{9'd10,  9'd13,  9'd16,  9'd30,  9'd33,  9'd23},
      '{9'd30,  9'd61,  9'd62,  9'd45,  9'd59,  9'd119},
      '{9'd116, 9'd90,  9'd156, 9'd198, 9'd373, 9'd326}
   };

   // datapath operations, one per sequencer step
   typedef enum logic [3:0] {
      OP_NONE,
      OP_MUL_C,
      OP_MUL_S,
      OP_ABS,
      OP_SQ,
      OP_AHI,
      OP_ALO,
      OP_WSUM,
      OP_POS,
      OP_SC_E,
      OP_SC_T,
      OP_SC_LO,
      OP_SC_HI,
      OP_SC_OUT
   } op_type;

   typedef struct packed {
      logic   accept;
      logic   load_out;
      logic   axis;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic last_class;
      logic keep;
   } status_type;

endpackage

### src/yolo_grid_cell_decode.sv
// ----------------------------------------------------------------------------
// yolo_grid_cell_decode
// Decodes int8 detection head values for one scale, fed cell-major one
// channel value per request, into a box, a score and a class per kept cell.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  req       in   req_valid/req_ready    raw_value, channel, anchor_index, row, col
//  rsp       out  rsp_valid/rsp_ready    box_left/top/width/height, score, class, anchor
//  csr       in   csr_valid/csr_ready    csr_index (3b), csr_wdata (64b)
//
//  req_ready stays high after a request that is not the last class channel.
//  The last class channel is followed by a check state; a kept cell then runs
//  21 steps on the shared multiplier datapath (8 per box axis, 5 for the score)
//  and a load state, and req_ready stays low until that load is done.
//  Reset is synchronous: registers return to defaults, cell values and argmax to zero.
//  A result waits in the output register while requests continue; a later
//  kept cell holds in its load cycle until that result is taken.
// ----------------------------------------------------------------------------
module yolo_grid_cell_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [7:0]  req_raw_value,
   input  logic [6:0]         req_channel,
   input  logic [1:0]         req_anchor_index,
   input  logic [6:0]         req_cell_row,
   input  logic [6:0]         req_cell_col,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_box_left,
   output logic signed [15:0] rsp_box_top,
   output logic [14:0]        rsp_box_width,
   output logic [14:0]        rsp_box_height,
   output logic signed [17:0] rsp_score,
   output logic [6:0]         rsp_class_id,
   output logic [1:0]         rsp_anchor_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   ygcd_pkg::cfg_type     cfg;
   ygcd_pkg::cmd_type     cmd;
   ygcd_pkg::status_type  status;

   ygcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ygcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ygcd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_raw_value    (req_raw_value),
      .req_channel      (req_channel),
      .req_anchor_index (req_anchor_index),
      .req_cell_row     (req_cell_row),
      .req_cell_col     (req_cell_col),
      .rsp_box_left     (rsp_box_left),
      .rsp_box_top      (rsp_box_top),
      .rsp_box_width    (rsp_box_width),
      .rsp_box_height   (rsp_box_height),
      .rsp_score        (rsp_score),
      .rsp_class_id     (rsp_class_id),
      .rsp_anchor_out   (rsp_anchor_out)
   );

endmodule

### src/ygcd_csr.sv
// ----------------------------------------------------------------------------
// ygcd_csr
// Configuration registers of the grid cell decoder, written one per request.
// ----------------------------------------------------------------------------
module ygcd_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_wdata,
   output ygcd_pkg::cfg_type   cfg
);

   ygcd_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ygcd_pkg::CFG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            ygcd_pkg::REG_SCALE_LEVEL: begin
               cfg_ff.scale_level <= csr_wdata[1:0];
            end
            ygcd_pkg::REG_ZERO_POINT: begin
               cfg_ff.zero_point <= csr_wdata[7:0];
            end
            ygcd_pkg::REG_QUANT_SCALE: begin
               cfg_ff.quant_scale <= csr_wdata[23:0];
            end
            ygcd_pkg::REG_THRESHOLD_Q: begin
               cfg_ff.threshold_q <= csr_wdata[7:0];
            end
            ygcd_pkg::REG_CLASS_COUNT: begin
               cfg_ff.class_count <= csr_wdata[6:0];
            end
            ygcd_pkg::REG_FILTER_ON: begin
               cfg_ff.class_filter_on <= csr_wdata[0];
            end
            ygcd_pkg::REG_CLASS_MASK: begin
               cfg_ff.class_mask <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

### src/ygcd_ctrl.sv
// ----------------------------------------------------------------------------
// ygcd_ctrl
// Controller: takes requests, checks a finished cell, steps the shared
// multiplier datapath through the box and score sequence, loads the result.
// ----------------------------------------------------------------------------
module ygcd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ygcd_pkg::status_type   status,
   output ygcd_pkg::cmd_type      cmd
);

   typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_RUN, ST_EMIT} state_type;

   state_type         state_ff, state_in;
   ygcd_pkg::op_type  op_ff, op_in;
   logic              axis_ff, axis_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              load_out;

   always_comb begin
      accept       = req_valid && (state_ff == ST_IDLE);
      load_out     = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
      state_in     = state_ff;
      op_in        = op_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept && status.last_class) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.keep) begin
               state_in = ST_RUN;
               op_in    = ygcd_pkg::OP_MUL_C;
               axis_in  = 1'b0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RUN: begin
            case (op_ff)
               ygcd_pkg::OP_MUL_C:  op_in = ygcd_pkg::OP_MUL_S;
               ygcd_pkg::OP_MUL_S:  op_in = ygcd_pkg::OP_ABS;
               ygcd_pkg::OP_ABS:    op_in = ygcd_pkg::OP_SQ;
               ygcd_pkg::OP_SQ:     op_in = ygcd_pkg::OP_AHI;
               ygcd_pkg::OP_AHI:    op_in = ygcd_pkg::OP_ALO;
               ygcd_pkg::OP_ALO:    op_in = ygcd_pkg::OP_WSUM;
               ygcd_pkg::OP_WSUM:   op_in = ygcd_pkg::OP_POS;
               ygcd_pkg::OP_POS: begin
                  // after the x axis repeat for y, after y go on to the score
                  if (axis_ff) begin
                     op_in = ygcd_pkg::OP_SC_E;
                  end else begin
                     op_in   = ygcd_pkg::OP_MUL_C;
                     axis_in = 1'b1;
                  end
               end
               ygcd_pkg::OP_SC_E:   op_in = ygcd_pkg::OP_SC_T;
               ygcd_pkg::OP_SC_T:   op_in = ygcd_pkg::OP_SC_LO;
               ygcd_pkg::OP_SC_LO:  op_in = ygcd_pkg::OP_SC_HI;
               ygcd_pkg::OP_SC_HI:  op_in = ygcd_pkg::OP_SC_OUT;
               ygcd_pkg::OP_SC_OUT: begin
                  op_in    = ygcd_pkg::OP_NONE;
                  state_in = ST_EMIT;
               end
               default: begin
                  op_in    = ygcd_pkg::OP_NONE;
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_EMIT: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= ygcd_pkg::OP_NONE;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign cmd.accept   = accept;
   assign cmd.load_out = load_out;
   assign cmd.axis     = axis_ff;
   assign cmd.op       = op_ff;

endmodule

### src/ygcd_dp.sv
// ----------------------------------------------------------------------------
// ygcd_dp
// Datapath: per-cell raw values and running class argmax, one shared
// 30x30 signed multiplier with its step registers, result staging and the
// output register.
// ----------------------------------------------------------------------------
module ygcd_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  ygcd_pkg::cfg_type      cfg,
   input  ygcd_pkg::cmd_type      cmd,
   output ygcd_pkg::status_type   status,
   input  logic signed [7:0]      req_raw_value,
   input  logic [6:0]             req_channel,
   input  logic [1:0]             req_anchor_index,
   input  logic [6:0]             req_cell_row,
   input  logic [6:0]             req_cell_col,
   output logic signed [15:0]     rsp_box_left,
   output logic signed [15:0]     rsp_box_top,
   output logic [14:0]            rsp_box_width,
   output logic [14:0]            rsp_box_height,
   output logic signed [17:0]     rsp_score,
   output logic [6:0]             rsp_class_id,
   output logic [1:0]             rsp_anchor_out
);

   function automatic logic signed [8:0] zdiff(input logic signed [7:0] q,
                                               input logic signed [7:0] zp);
      zdiff = {q[7], q} - {zp[7], zp};
   endfunction

   function automatic logic signed [15:0] sat_s16(input logic signed [30:0] v);
      if (v > 31'sd32767) begin
         sat_s16 = 16'sh7fff;
      end else if (v < -31'sd32768) begin
         sat_s16 = 16'sh8000;
      end else begin
         sat_s16 = v[15:0];
      end
   endfunction

   function automatic logic signed [17:0] sat_s18(input logic signed [41:0] v);
      if (v > 42'sd131071) begin
         sat_s18 = 18'sh1ffff;
      end else if (v < -42'sd131072) begin
         sat_s18 = 18'sh20000;
      end else begin
         sat_s18 = v[17:0];
      end
   endfunction

   // per-cell state
   logic signed [7:0]  box_x_ff, box_y_ff, box_w_ff, box_h_ff;
   logic signed [7:0]  obj_ff, best_ff;
   logic [6:0]         best_idx_ff;
   logic [6:0]         row_ff, col_ff;
   logic [1:0]         anchor_ff;

   // step registers
   logic signed [59:0] prod_ff;
   logic signed [34:0] center_ff, center_in;
   logic [28:0]        m_ff, m_in;
   logic [19:0]        mlo_ff;
   logic [49:0]        w_ff, w_in;
   logic signed [16:0] thi_ff;
   logic [47:0]        acc_ff;

   // staged result
   logic signed [15:0] stage_left_ff, stage_top_ff;
   logic [14:0]        stage_width_ff, stage_height_ff;
   logic signed [17:0] stage_score_ff;

   // output register
   logic signed [15:0] out_left_ff, out_top_ff;
   logic [14:0]        out_width_ff, out_height_ff;
   logic signed [17:0] out_score_ff;
   logic [6:0]         out_class_ff;
   logic [1:0]         out_anchor_ff;

   logic [6:0]         cnt_eff;
   logic [6:0]         ch_limit;
   logic [1:0]         lvl;
   logic [8:0]         anc;
   logic signed [7:0]  q_center, q_size;
   logic [6:0]         grid_idx;
   logic signed [8:0]  zd_center, zd_size, zd_best, zd_obj;
   logic signed [29:0] mul_a, mul_b;
   logic signed [59:0] prod_in;
   logic               mul_en;
   logic signed [34:0] two_d;
   logic [34:0]        mag;
   logic signed [51:0] center_sh, pos_sum;
   logic [49:0]        size_sum;
   logic signed [15:0] pos_val;
   logic [14:0]        size_val;
   logic [48:0]        frac_sum;
   logic signed [41:0] score_sum;
   logic               obj_ok, best_ok, class_ok;

   assign cnt_eff  = (cfg.class_count == 7'd0) ? 7'd1 :
                     (cfg.class_count > ygcd_pkg::MAX_CLASSES) ? ygcd_pkg::MAX_CLASSES :
                     cfg.class_count;
   assign ch_limit = cnt_eff + 7'd5;
   assign lvl      = (cfg.scale_level == 2'd3) ? 2'd2 : cfg.scale_level;
   assign anc      = ygcd_pkg::ANCHOR_TAB[lvl][{anchor_ff, cmd.axis}];

   assign q_center = cmd.axis ? box_y_ff : box_x_ff;
   assign q_size   = cmd.axis ? box_h_ff : box_w_ff;
   assign grid_idx = cmd.axis ? row_ff : col_ff;

   assign zd_center = zdiff(q_center, cfg.zero_point);
   assign zd_size   = zdiff(q_size, cfg.zero_point);
   assign zd_best   = zdiff(best_ff, cfg.zero_point);
   assign zd_obj    = zdiff(obj_ff, cfg.zero_point);

   // decision for the finished cell
   assign obj_ok   = !(obj_ff < $signed(cfg.threshold_q));
   assign best_ok  = best_ff > $signed(cfg.threshold_q);
   assign class_ok = !cfg.class_filter_on ||
                     (!best_idx_ff[6] && cfg.class_mask[best_idx_ff[5:0]]);

   assign status.last_class = (req_channel == cnt_eff + 7'd4);
   assign status.keep       = obj_ok && best_ok && class_ok;

   // accumulate the cell
   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff    <= '0;
         box_y_ff    <= '0;
         box_w_ff    <= '0;
         box_h_ff    <= '0;
         obj_ff      <= '0;
         best_ff     <= '0;
         best_idx_ff <= '0;
      end else if (cmd.accept) begin
         if (req_channel == 7'd0) begin
            box_x_ff <= req_raw_value;
         end else if (req_channel == 7'd1) begin
            box_y_ff <= req_raw_value;
         end else if (req_channel == 7'd2) begin
            box_w_ff <= req_raw_value;
         end else if (req_channel == 7'd3) begin
            box_h_ff <= req_raw_value;
         end else if (req_channel == 7'd4) begin
            obj_ff <= req_raw_value;
         end else if (req_channel < ch_limit) begin
            // first class restarts the argmax; a tie keeps the earlier class
            if (req_channel == 7'd5 || req_raw_value > best_ff) begin
               best_ff     <= req_raw_value;
               best_idx_ff <= req_channel - 7'd5;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         row_ff    <= req_cell_row;
         col_ff    <= req_cell_col;
         anchor_ff <= (req_anchor_index == 2'd3) ? 2'd2 : req_anchor_index;
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b0;
      case (cmd.op)
         ygcd_pkg::OP_MUL_C: begin
            mul_a  = {{21{zd_center[8]}}, zd_center};
            mul_b  = {6'd0, cfg.quant_scale};
            mul_en = 1'b1;
         end
         ygcd_pkg::OP_MUL_S: begin
            mul_a  = {{21{zd_size[8]}}, zd_size};
            mul_b  = {6'd0, cfg.quant_scale};
            mul_en = 1'b1;
         end
         ygcd_pkg::OP_SQ: begin
            mul_a  = {1'b0, m_ff};
            mul_b  = {1'b0, m_ff};
            mul_en = 1'b1;
         end
         ygcd_pkg::OP_AHI: begin
            mul_a  = {9'd0, prod_ff[56:36]};
            mul_b  = {21'd0, anc};
            mul_en = 1'b1;
         end
         ygcd_pkg::OP_ALO: begin
            mul_a  = {10'd0, mlo_ff};
            mul_b  = {21'd0, anc};
            mul_en = 1'b1;
         end
         ygcd_pkg::OP_SC_E: begin
            mul_a  = {{21{zd_best[8]}}, zd_best};
            mul_b  = {{21{zd_obj[8]}}, zd_obj};
            mul_en = 1'b1;
         end
         ygcd_pkg::OP_SC_T: begin
            mul_a  = {{13{prod_ff[16]}}, prod_ff[16:0]};
            mul_b  = {6'd0, cfg.quant_scale};
            mul_en = 1'b1;
         end
         ygcd_pkg::OP_SC_LO: begin
            mul_a  = {6'd0, prod_ff[23:0]};
            mul_b  = {6'd0, cfg.quant_scale};
            mul_en = 1'b1;
         end
         ygcd_pkg::OP_SC_HI: begin
            mul_a  = {{13{thi_ff[16]}}, thi_ff};
            mul_b  = {6'd0, cfg.quant_scale};
            mul_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // center: 2*d - 1/2 + cell, Q20
   assign two_d     = $signed({prod_ff[32], prod_ff[32:0], 1'b0});
   assign center_in = two_d - 35'sd524288 + $signed({8'd0, grid_idx, 20'd0});

   // size magnitude, clamped to 256.0
   assign mag  = two_d[34] ? 35'(-two_d) : 35'(two_d);
   assign m_in = (mag > 35'd268435456) ? 29'h1000_0000 : mag[28:0];

   assign w_in = (cmd.op == ygcd_pkg::OP_ALO) ? {prod_ff[29:0], 20'd0}
                                              : w_ff + {21'd0, prod_ff[28:0]};

   // position and size rounding
   always_comb begin
      case (lvl)
         2'd0:    center_sh = {{17{center_ff[34]}}, center_ff} <<< 8;
         2'd1:    center_sh = {{17{center_ff[34]}}, center_ff} <<< 9;
         default: center_sh = {{17{center_ff[34]}}, center_ff} <<< 10;
      endcase
   end

   assign pos_sum  = center_sh - $signed({2'b00, w_ff}) + 52'sd1048576;
   assign pos_val  = sat_s16(pos_sum[51:21]);
   assign size_sum = w_ff + 50'd524288;
   assign size_val = (|size_sum[49:35]) ? 15'h7fff : size_sum[34:20];

   // score: t*S split as hi*S + round(lo*S / 2^24)
   assign frac_sum  = {1'b0, acc_ff} + 49'd8388608;
   assign score_sum = $signed({prod_ff[40], prod_ff[40:0]}) + $signed({17'd0, frac_sum[48:24]});

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      case (cmd.op)
         ygcd_pkg::OP_MUL_S: center_ff <= center_in;
         ygcd_pkg::OP_ABS:   m_ff      <= m_in;
         ygcd_pkg::OP_AHI:   mlo_ff    <= prod_ff[35:16];
         ygcd_pkg::OP_ALO:   w_ff      <= w_in;
         ygcd_pkg::OP_WSUM:  w_ff      <= w_in;
         ygcd_pkg::OP_POS: begin
            if (cmd.axis) begin
               stage_top_ff    <= pos_val;
               stage_height_ff <= size_val;
            end else begin
               stage_left_ff   <= pos_val;
               stage_width_ff  <= size_val;
            end
         end
         ygcd_pkg::OP_SC_LO:  thi_ff         <= prod_ff[40:24];
         ygcd_pkg::OP_SC_HI:  acc_ff         <= prod_ff[47:0];
         ygcd_pkg::OP_SC_OUT: stage_score_ff <= sat_s18(score_sum);
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_left_ff   <= stage_left_ff;
         out_top_ff    <= stage_top_ff;
         out_width_ff  <= stage_width_ff;
         out_height_ff <= stage_height_ff;
         out_score_ff  <= stage_score_ff;
         out_class_ff  <= best_idx_ff;
         out_anchor_ff <= anchor_ff;
      end
   end

   assign rsp_box_left   = out_left_ff;
   assign rsp_box_top    = out_top_ff;
   assign rsp_box_width  = out_width_ff;
   assign rsp_box_height = out_height_ff;
   assign rsp_score      = out_score_ff;
   assign rsp_class_id   = out_class_ff;
   assign rsp_anchor_out = out_anchor_ff;

endmodule

### tb/yolo_grid_cell_decode_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// yolo_grid_cell_decode_test
// Self-checking bench for the grid cell decoder. Streams channel values cell
// by cell, predicts every kept box, score and class with a shadow decoder,
// and checks each response in order across register settings and pacing.
// ----------------------------------------------------------------------------
module yolo_grid_cell_decode_test;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 32;
   localparam int SHOW_LIMIT     = 10;

   typedef enum int {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_type;

   typedef struct packed {
      logic signed [15:0] box_left;
      logic signed [15:0] box_top;
      logic [14:0]        box_width;
      logic [14:0]        box_height;
      logic signed [17:0] score;
      logic [6:0]         class_id;
      logic [1:0]         anchor_out;
   } box_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [7:0]  req_raw_value = '0;
   logic [6:0]         req_channel = '0;
   logic [1:0]         req_anchor_index = '0;
   logic [6:0]         req_cell_row = '0;
   logic [6:0]         req_cell_col = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_box_left;
   logic signed [15:0] rsp_box_top;
   logic [14:0]        rsp_box_width;
   logic [14:0]        rsp_box_height;
   logic signed [17:0] rsp_score;
   logic [6:0]         rsp_class_id;
   logic [1:0]         rsp_anchor_out;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = ygcd_pkg::REG_SCALE_LEVEL;
   logic [63:0]        csr_wdata = '0;

   // shadow decoder state
   ygcd_pkg::cfg_type shadow_cfg = ygcd_pkg::CFG_RESET;
   logic signed [7:0] box_raw [0:3] = '{default: 8'sd0};
   logic signed [7:0] obj_raw = '0;
   logic signed [7:0] best_raw = '0;
   logic [6:0]        best_class = '0;

   box_type pending_boxes [$];
   box_type seen_box;
   box_type want_box;

   int mismatches    = 0;
   int requests_sent = 0;
   int boxes_checked = 0;
   int reg_writes    = 0;
   int idle_cycles   = 0;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;

   yolo_grid_cell_decode u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_raw_value    (req_raw_value),
      .req_channel      (req_channel),
      .req_anchor_index (req_anchor_index),
      .req_cell_row     (req_cell_row),
      .req_cell_col     (req_cell_col),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_box_left     (rsp_box_left),
      .rsp_box_top      (rsp_box_top),
      .rsp_box_width    (rsp_box_width),
      .rsp_box_height   (rsp_box_height),
      .rsp_score        (rsp_score),
      .rsp_class_id     (rsp_class_id),
      .rsp_anchor_out   (rsp_anchor_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- shadow math

   function automatic longint dequant(logic signed [7:0] q);
      return (longint'(q) - longint'($signed(shadow_cfg.zero_point)))
             * longint'(shadow_cfg.quant_scale);
   endfunction

   // floor of v / 2^sh, rounded half up
   function automatic longint round_shift(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int class_total();
      if (shadow_cfg.class_count == 0) return 1;
      if (shadow_cfg.class_count > ygcd_pkg::MAX_CLASSES) return int'(ygcd_pkg::MAX_CLASSES);
      return int'(shadow_cfg.class_count);
   endfunction

   function automatic void decode_axis(input logic signed [7:0] q_ctr,
                                       input logic signed [7:0] q_ext,
                                       input longint grid_pos, input longint stride,
                                       input longint anchor_dim,
                                       output logic [15:0] pos, output logic [14:0] extent);
      longint ctr, s2, mag, w24, p, s;
      ctr = (2 * dequant(q_ctr) - 524288 + grid_pos * 1048576) * stride * 16;
      s2  = 2 * dequant(q_ext);
      mag = (s2 < 0) ? -s2 : s2;
      // anything past 256 saturates every dependent field already
      if (mag > 268435456) mag = 268435456;
      w24 = ((mag * mag) >>> 16) * anchor_dim;
      p = clamp(round_shift(2 * ctr - w24, 21), -32768, 32767);
      s = clamp(round_shift(w24, 20), 0, 32767);
      pos    = p[15:0];
      extent = s[14:0];
   endfunction

   function automatic bit decode_value(input logic signed [7:0] raw, input logic [6:0] chan,
                                       input logic [1:0] anc_in, input logic [6:0] row,
                                       input logic [6:0] col, output box_type box);
      int                n_class, lvl, slot, thr;
      longint            stride, a, b, p, sc;
      longint unsigned   am, bm;
      bit                neg;
      logic [15:0]       left, top;
      logic [14:0]       wid, hgt;
      box = '0;
      n_class = class_total();
      slot = (anc_in > 2'd2) ? 2 : int'(anc_in);
      if (chan < 4) begin
         box_raw[chan[1:0]] = raw;
         return 1'b0;
      end
      if (chan == 4) begin
         obj_raw = raw;
         return 1'b0;
      end
      if (chan >= 5 + n_class) return 1'b0;
      // first maximum wins a tie
      if (chan == 5) begin
         best_raw   = raw;
         best_class = '0;
      end else if (raw > best_raw) begin
         best_raw   = raw;
         best_class = chan - 7'd5;
      end
      if (chan != 4 + n_class) return 1'b0;

      thr = int'($signed(shadow_cfg.threshold_q));
      if (int'(obj_raw) < thr) return 1'b0;
      if (int'(best_raw) <= thr) return 1'b0;
      if (shadow_cfg.class_filter_on) begin
         if (best_class >= 64) return 1'b0;
         if (!shadow_cfg.class_mask[best_class[5:0]]) return 1'b0;
      end

      lvl = (shadow_cfg.scale_level > 2'd2) ? 2 : int'(shadow_cfg.scale_level);
      stride = longint'(8) << lvl;
      decode_axis(box_raw[0], box_raw[2], longint'(col), stride,
                  longint'(ygcd_pkg::ANCHOR_TAB[lvl][2 * slot]), left, wid);
      decode_axis(box_raw[1], box_raw[3], longint'(row), stride,
                  longint'(ygcd_pkg::ANCHOR_TAB[lvl][2 * slot + 1]), top, hgt);

      a = dequant(best_raw);
      b = dequant(obj_raw);
      am = (a < 0) ? -a : a;
      bm = (b < 0) ? -b : b;
      neg = (a < 0) != (b < 0);
      if (am != 0 && bm > (64'd1 << 41) / am) begin
         sc = neg ? -131072 : 131071;
      end else begin
         p = longint'(am * bm);
         if (neg) p = -p;
         sc = clamp(round_shift(p, 24), -131072, 131071);
      end

      box.box_left   = left;
      box.box_top    = top;
      box.box_width  = wid;
      box.box_height = hgt;
      box.score      = sc[17:0];
      box.class_id   = best_class;
      box.anchor_out = slot[1:0];
      return 1'b1;
   endfunction

   function automatic ygcd_pkg::cfg_type make_cfg(int lvl, int zp, int scale, int thr,
                                                  int count, int filt, logic [63:0] mask);
      ygcd_pkg::cfg_type c;
      c.scale_level     = lvl[1:0];
      c.zero_point      = zp[7:0];
      c.quant_scale     = scale[23:0];
      c.threshold_q     = thr[7:0];
      c.class_count     = count[6:0];
      c.class_filter_on = filt[0];
      c.class_mask      = mask;
      return c;
   endfunction

   // ---------------------------------------------------------------- drivers

   // entered and left at a falling edge; valid stays high for a following request
   task automatic send_value(input logic signed [7:0] raw, input logic [6:0] chan,
                             input logic [1:0] anc, input logic [6:0] row,
                             input logic [6:0] col);
      box_type box;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_raw_value    <= raw;
      req_channel      <= chan;
      req_anchor_index <= anc;
      req_cell_row     <= row;
      req_cell_col     <= col;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (decode_value(raw, chan, anc, row, col, box))
         pending_boxes.insert(pending_boxes.size(), box);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic csr_put(input logic [2:0] idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         ygcd_pkg::REG_SCALE_LEVEL: shadow_cfg.scale_level     = data[1:0];
         ygcd_pkg::REG_ZERO_POINT:  shadow_cfg.zero_point      = data[7:0];
         ygcd_pkg::REG_QUANT_SCALE: shadow_cfg.quant_scale     = data[23:0];
         ygcd_pkg::REG_THRESHOLD_Q: shadow_cfg.threshold_q     = data[7:0];
         ygcd_pkg::REG_CLASS_COUNT: shadow_cfg.class_count     = data[6:0];
         ygcd_pkg::REG_FILTER_ON:   shadow_cfg.class_filter_on = data[0];
         ygcd_pkg::REG_CLASS_MASK:  shadow_cfg.class_mask      = data;
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
   endtask

   // upper bits carry junk, the decoder keeps only the field width
   task automatic load_config(input ygcd_pkg::cfg_type c);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      csr_put(ygcd_pkg::REG_SCALE_LEVEL, {junk[63:2], c.scale_level});
      csr_put(ygcd_pkg::REG_ZERO_POINT, {junk[63:8], c.zero_point});
      csr_put(ygcd_pkg::REG_QUANT_SCALE, {junk[63:24], c.quant_scale});
      csr_put(ygcd_pkg::REG_THRESHOLD_Q, {junk[63:8], c.threshold_q});
      csr_put(ygcd_pkg::REG_CLASS_COUNT, {junk[63:7], c.class_count});
      csr_put(ygcd_pkg::REG_FILTER_ON, {junk[63:1], c.class_filter_on});
      csr_put(ygcd_pkg::REG_CLASS_MASK, c.class_mask);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_boxes.size() != 0) @(negedge clock);
      // a dropped cell may still be in its check cycle
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic prepare_phase(input ygcd_pkg::cfg_type c, input pace_type pace);
      wait_drained();
      load_config(c);
      case (pace)
         PACE_NONE: begin
            req_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         PACE_SENDER: begin
            req_idle_pct = 88;
            rsp_stall_pct = 0;
         end
         PACE_RECEIVER: begin
            req_idle_pct = 0;
            rsp_stall_pct = 88;
         end
         default: begin
            req_idle_pct = 12;
            rsp_stall_pct = 12;
         end
      endcase
   endtask

   // mostly whole cells in order, some cut at the head or tail, some lone noise
   task automatic random_cell(input int n_class);
      logic [1:0]        anc;
      logic [6:0]        row, col;
      int                kind, first, last, chan, thr, lo;
      logic signed [7:0] v, top_val;
      anc  = 2'($urandom_range(3));
      row  = 7'($urandom_range(127));
      col  = 7'($urandom_range(127));
      kind = $urandom_range(99);
      thr  = int'($signed(shadow_cfg.threshold_q));
      lo   = (thr < 127) ? thr + 1 : 127;
      if (kind < 10) begin
         send_value(8'($urandom), 7'($urandom_range(127)), anc, row, col);
      end else begin
         first = 0;
         last  = 4 + n_class;
         if (kind < 22) begin
            if ($urandom_range(1)) first = $urandom_range(last);
            else last = $urandom_range(last);
         end
         top_val = -8'sd128;
         for (chan = first; chan <= last; chan++) begin
            if (chan < 4) begin
               v = 8'($urandom);
            end else if (chan == 4) begin
               v = ($urandom_range(3) != 0) ? 8'(thr + $urandom_range(127 - thr))
                                            : 8'($urandom);
            end else begin
               case ($urandom_range(7))
                  0: v = top_val;
                  1, 2, 3: v = 8'(lo + $urandom_range(127 - lo));
                  default: v = 8'($urandom);
               endcase
               if (chan == 5 || v > top_val) top_val = v;
            end
            if ($urandom_range(15) == 0) begin
               anc = 2'($urandom_range(3));
               row = 7'($urandom_range(127));
               col = 7'($urandom_range(127));
            end
            send_value(v, chan[6:0], anc, row, col);
         end
      end
   endtask

   task automatic run_phase(input ygcd_pkg::cfg_type c, input pace_type pace,
                            input int n_items);
      int first_sent;
      prepare_phase(c, pace);
      first_sent = requests_sent;
      while (requests_sent - first_sent < n_items) begin
         random_cell(class_total());
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_extreme_cells();
      int chan;
      prepare_phase(make_cfg(3, -128, 24'hFFFFFF, -128, 0, 0, 64'd0), PACE_NONE);
      for (chan = 0; chan <= 5; chan++) send_value(8'sd127, chan[6:0], 2'd3, 7'd127, 7'd127);
      // equal to the threshold: objectness passes, class score does not
      for (chan = 0; chan <= 5; chan++) send_value(-8'sd128, chan[6:0], 2'd0, 7'd0, 7'd0);
      send_value(8'sd5, 7'd6, 2'd2, 7'd10, 7'd20);
      send_value(-8'sd1, 7'd127, 2'd1, 7'd100, 7'd3);
      // lone class channel decides on the state left behind
      send_value(8'sd0, 7'd5, 2'd1, 7'd64, 7'd1);
   endtask

   task automatic test_class_tie_and_whitelist();
      prepare_phase(make_cfg(1, 0, 65536, 0, 2, 1, 64'h1), PACE_NONE);
      send_value(8'sd16, 7'd0, 2'd1, 7'd5, 7'd9);
      send_value(-8'sd16, 7'd1, 2'd1, 7'd5, 7'd9);
      send_value(8'sd8, 7'd2, 2'd1, 7'd5, 7'd9);
      send_value(-8'sd8, 7'd3, 2'd1, 7'd5, 7'd9);
      send_value(8'sd40, 7'd4, 2'd1, 7'd5, 7'd9);
      send_value(8'sd50, 7'd5, 2'd1, 7'd5, 7'd9);
      send_value(8'sd50, 7'd6, 2'd1, 7'd5, 7'd9);
      send_value(8'sd0, 7'd4, 2'd0, 7'd6, 7'd2);
      send_value(8'sd1, 7'd5, 2'd0, 7'd6, 7'd2);
      send_value(8'sd2, 7'd6, 2'd0, 7'd6, 7'd2);
      send_value(8'sd1, 7'd5, 2'd2, 7'd7, 7'd3);
      send_value(8'sd0, 7'd6, 2'd2, 7'd7, 7'd3);
   endtask

   task automatic test_streaming();
      run_phase(make_cfg(0, 0, 104858, -20, 3, 0, 64'd0), PACE_NONE, 300);
      run_phase(make_cfg(2, 5, 20000, -128, 80, 1, '1), PACE_NONE, 300);
   endtask

   task automatic test_sender_gaps();
      run_phase(make_cfg(1, -128, 8000, 10, 5, 1, {$urandom, $urandom}), PACE_SENDER, 250);
      run_phase(make_cfg(0, $urandom_range(255), 0, $urandom_range(255), 127, 0, 64'd0),
                PACE_SENDER, 150);
   endtask

   task automatic test_receiver_stalls();
      run_phase(make_cfg(2, 127, 24'hFFFFFF, -128, 1, 0, 64'd0), PACE_RECEIVER, 250);
      run_phase(make_cfg(1, 0, $urandom_range(24'hFFFFFF), 127, 2, 0, 64'd0),
                PACE_RECEIVER, 60);
   endtask

   task automatic test_mixed_idling();
      run_phase(make_cfg(3, $urandom_range(255), $urandom_range(24'hFFFFFF),
                         int'($urandom_range(40)) - 20, 4, 1, '1), PACE_BOTH, 300);
      run_phase(make_cfg(0, -5, 1 << 20, 0, 0, 1, {$urandom, $urandom} | 64'd1),
                PACE_BOTH, 250);
   endtask

   // ---------------------------------------------------------------- checking

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_box = {rsp_box_left, rsp_box_top, rsp_box_width, rsp_box_height,
                     rsp_score, rsp_class_id, rsp_anchor_out};
         if (pending_boxes.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
               $display("unexpected response: left %0d top %0d class %0d anchor %0d",
                        $signed(seen_box.box_left), $signed(seen_box.box_top),
                        seen_box.class_id, seen_box.anchor_out);
         end else begin
            want_box = pending_boxes.pop_front();
            boxes_checked++;
            if (seen_box !== want_box) begin
               mismatches++;
               if (mismatches <= SHOW_LIMIT) begin
                  $display("box %0d expected: l %0d t %0d w %0d h %0d sc %0d c %0d a %0d",
                           boxes_checked, $signed(want_box.box_left),
                           $signed(want_box.box_top), want_box.box_width,
                           want_box.box_height, $signed(want_box.score),
                           want_box.class_id, want_box.anchor_out);
                  $display("box %0d actual:   l %0d t %0d w %0d h %0d sc %0d c %0d a %0d",
                           boxes_checked, $signed(seen_box.box_left),
                           $signed(seen_box.box_top), seen_box.box_width,
                           seen_box.box_height, $signed(seen_box.score),
                           seen_box.class_id, seen_box.anchor_out);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("no handshake for %0d cycles, %0d boxes outstanding",
                  idle_cycles, pending_boxes.size());
         $display("yolo_grid_cell_decode test failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extreme_cells();
      test_class_tie_and_whitelist();
      test_streaming();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();
      wait_drained();
      $display("sent %0d channel values, checked %0d decoded boxes, %0d register writes",
               requests_sent, boxes_checked, reg_writes);
      $display("covered class counts 0 to 127, all scale levels, whitelist and four pacing modes");
      if (mismatches == 0) begin
         $display("yolo_grid_cell_decode test passed");
      end else begin
         $display("%0d mismatching responses", mismatches);
         $display("yolo_grid_cell_decode test failed");
      end
      $finish;
   end

endmodule
